>>> src/pbeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbeq_pkg;

    typedef enum logic [2:0] {
        ACT_SUB   = 3'd0,
        ACT_UNSUB = 3'd1,
        ACT_UNALL = 3'd2,
        ACT_QUERY = 3'd3,
        ACT_PUSH  = 3'd4,
        ACT_ANY   = 3'd5,
        ACT_ENUM  = 3'd6,
        ACT_RESET = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    localparam int CFG_DYNAMIC = 0;
    localparam int CFG_STATIC  = 1;
    localparam int CFG_WIDTH   = 9;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_WIDTH-1:0] COUNT_RESET = 9'd256;

endpackage
`default_nettype wire

>>> src/pbeq_body_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-body record: subscription mask, list head, tail and length.
// Length and mask are cleared by a sweep after reset; the reset action
// rewrites every record with a zero length and its mask kept.
module pbeq_body_mem #(
    parameter int AW = 9,
    parameter int PW = 6,
    parameter int LW = 7
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_mask,
    output logic [PW-1:0]      rd_head,
    output logic [PW-1:0]      rd_tail,
    output logic [LW-1:0]      rd_len,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_mask,
    input  wire logic [PW-1:0] wr_head,
    input  wire logic [PW-1:0] wr_tail,
    input  wire logic [LW-1:0] wr_len
);
    localparam int W = 8 + 2 * PW + LW;
    logic [W-1:0] mem [2**AW];
    logic [W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_mask, wr_head, wr_tail, wr_len};
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign {rd_mask, rd_head, rd_tail, rd_len} = q_reg;
endmodule
`default_nettype wire

>>> src/per_body_event_queue_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                                                          | dir
// in      | in_valid/in_stall, action body_kind body_index event_mask event_data | in
// out     | out_valid/out_stall, status flag has_event event_out last         | out
// cfg     | cfg_we cfg_index cfg_data                                         | in
// An action passes through accept, body read, update and output load; the next
// word is accepted only once the previous result is loaded. Enumerate emits one
// word per cycle while the output does not stall. After reset a sweep clears the
// body memory, during which no word is accepted; the reset action sweeps the
// lengths again. A waiting result stalls the input; an output stall holds the walk.
module per_body_event_queue_pool #(
    parameter int EVENT_CAPACITY  = 64,
    parameter int BODIES_PER_KIND = 256,
    parameter int PAYLOAD_WIDTH   = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [2:0]                        action,
    input  wire logic                              body_kind,
    input  wire logic [7:0]                        body_index,
    input  wire logic [7:0]                        event_mask,
    input  wire logic [PAYLOAD_WIDTH-1:0]          event_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic                                   flag,
    output logic                                   has_event,
    output logic [PAYLOAD_WIDTH-1:0]               event_out,
    output logic                                   last,
    input  wire logic                              cfg_we,
    input  wire logic [pbeq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [pbeq_pkg::CFG_WIDTH-1:0]    cfg_data
);
    import pbeq_pkg::*;

    localparam int BW = (BODIES_PER_KIND > 1) ? $clog2(BODIES_PER_KIND) : 1;
    localparam int AW = BW + 1;
    localparam int PW = $clog2(EVENT_CAPACITY);
    localparam int LW = $clog2(EVENT_CAPACITY + 1);
    localparam int NB = 2 * BODIES_PER_KIND;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_WALK, S_OUT, S_WIPE, S_WEND
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;
    logic [CFG_WIDTH-1:0] dyn_count_reg, sta_count_reg;
    logic [LW-1:0] used_reg;
    action_t act_reg;
    logic [AW-1:0] slot_reg;
    logic [7:0] emask_reg;
    logic [PAYLOAD_WIDTH-1:0] data_reg;
    logic bad_reg;
    logic [LW-1:0] left_reg;

    logic out_valid_reg, flag_reg, has_reg, last_reg;
    logic [1:0] status_reg;
    logic [PAYLOAD_WIDTH-1:0] eout_reg;

    // pool memories
    logic [PAYLOAD_WIDTH-1:0] store_mem [EVENT_CAPACITY];
    logic [PW-1:0] link_mem [EVENT_CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] store_q_reg;
    logic [PW-1:0] link_q_reg;
    logic st_we, lk_we, pool_re;
    logic [PW-1:0] st_wa, lk_wa, lk_wd, pool_ra;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= data_reg;
        end
        if (lk_we)
        begin
            link_mem[lk_wa] <= lk_wd;
        end
        if (pool_re)
        begin
            store_q_reg <= store_mem[pool_ra];
            link_q_reg  <= link_mem[pool_ra];
        end
    end

    // body memory
    logic b_re, b_we;
    logic [AW-1:0] b_ra, b_wa;
    logic [7:0] b_mask, w_mask;
    logic [PW-1:0] b_head, b_tail, w_head, w_tail;
    logic [LW-1:0] b_len, w_len;

    pbeq_body_mem #(.AW(AW), .PW(PW), .LW(LW)) u_body (
        .clk(clk), .rd_en(b_re), .rd_addr(b_ra),
        .rd_mask(b_mask), .rd_head(b_head), .rd_tail(b_tail),
        .rd_len(b_len),
        .wr_en(b_we), .wr_addr(b_wa), .wr_mask(w_mask), .wr_head(w_head),
        .wr_tail(w_tail), .wr_len(w_len)
    );

    logic [CFG_WIDTH-1:0] limit;
    logic in_ok, out_free;
    assign limit = body_kind ? sta_count_reg : dyn_count_reg;
    assign out_free = !out_valid_reg || !out_stall;
    // a held result word blocks a new one until it leaves
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_ok = in_valid && !in_stall;

    always_comb
    begin
        b_re = 1'b0;
        b_ra = slot_reg;
        b_we = 1'b0;
        b_wa = slot_reg;
        w_mask = b_mask;
        w_head = b_head;
        w_tail = b_tail;
        w_len = b_len;
        st_we = 1'b0;
        st_wa = used_reg[PW-1:0];
        lk_we = 1'b0;
        lk_wa = b_tail;
        lk_wd = used_reg[PW-1:0];
        pool_re = 1'b0;
        pool_ra = b_head;
        case (state_reg)
            S_CLEAR:
            begin
                b_we = 1'b1;
                b_wa = clr_reg;
                w_mask = '0;
                w_len = '0;
            end
            S_READ:
            begin
                b_re = 1'b1;
            end
            S_EXEC:
            begin
                if (!bad_reg)
                begin
                    case (act_reg)
                        ACT_SUB:   begin b_we = 1'b1; w_mask = b_mask | emask_reg; end
                        ACT_UNSUB: begin b_we = 1'b1; w_mask = b_mask & ~emask_reg; end
                        ACT_UNALL: begin b_we = 1'b1; w_mask = '0; end
                        ACT_PUSH:
                        begin
                            if (used_reg != LW'(EVENT_CAPACITY))
                            begin
                                b_we = 1'b1;
                                st_we = 1'b1;
                                lk_we = (b_len != '0);
                                if (b_len == '0)
                                begin
                                    w_head = used_reg[PW-1:0];
                                end
                                w_tail = used_reg[PW-1:0];
                                w_len = b_len + 1'b1;
                            end
                        end
                        ACT_ENUM:
                        begin
                            pool_re = 1'b1;
                            pool_ra = b_head;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free && left_reg != LW'(1))
                begin
                    pool_re = 1'b1;
                    pool_ra = link_q_reg;
                end
            end
            S_WIPE:
            begin
                // read entry n while entry n-1 goes back with a zero length
                b_re = 1'b1;
                b_ra = clr_reg;
                if (clr_reg != '0)
                begin
                    b_we = 1'b1;
                    b_wa = clr_reg - 1'b1;
                    w_len = '0;
                end
            end
            S_WEND:
            begin
                b_we = 1'b1;
                b_wa = clr_reg;
                w_len = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            dyn_count_reg <= COUNT_RESET;
            sta_count_reg <= COUNT_RESET;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_INDEX_WIDTH'(CFG_DYNAMIC))
                begin
                    dyn_count_reg <= cfg_data;
                end
                else
                begin
                    sta_count_reg <= cfg_data;
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(NB - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ok)
                    begin
                        act_reg <= action_t'(action);
                        slot_reg <= {body_kind, body_index[BW-1:0]};
                        emask_reg <= event_mask;
                        data_reg <= event_data;
                        bad_reg <= ({1'b0, body_index} >= limit)
                            || (32'(body_index) >= BODIES_PER_KIND);
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    status_reg <= ST_OK;
                    flag_reg <= 1'b0;
                    has_reg <= 1'b0;
                    eout_reg <= '0;
                    last_reg <= 1'b1;
                    state_reg <= S_OUT;
                    if (act_reg == ACT_RESET)
                    begin
                        used_reg <= '0;
                        clr_reg <= '0;
                        state_reg <= S_WIPE;
                    end
                    else if (bad_reg)
                    begin
                        status_reg <= ST_INVALID;
                    end
                    else
                    begin
                        case (act_reg)
                            ACT_QUERY: flag_reg <= |(b_mask & emask_reg);
                            ACT_ANY:   flag_reg <= (b_len != '0);
                            ACT_PUSH:
                            begin
                                if (used_reg == LW'(EVENT_CAPACITY))
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    used_reg <= used_reg + 1'b1;
                                end
                            end
                            ACT_ENUM:
                            begin
                                if (b_len != '0)
                                begin
                                    left_reg <= b_len;
                                    state_reg <= S_WALK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        has_reg <= 1'b1;
                        eout_reg <= store_q_reg;
                        last_reg <= (left_reg == LW'(1));
                        left_reg <= left_reg - 1'b1;
                        if (left_reg == LW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_WIPE:
                begin
                    if (clr_reg == AW'(NB - 1))
                    begin
                        state_reg <= S_WEND;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_WEND:
                begin
                    state_reg <= S_OUT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign flag = flag_reg;
    assign has_event = has_reg;
    assign event_out = eout_reg;
    assign last = last_reg;
endmodule
`default_nettype wire

>>> src/pbeq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pbeq_checker #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [1:0] status,
    input wire logic has_event,
    input wire logic [PAYLOAD_WIDTH-1:0] event_out,
    input wire logic flag
);
    import pbeq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_out))
        else $error("stalled word changed");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");
    a_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_event |-> status == ST_OK && !flag)
        else $error("event word with status");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_event |-> event_out == '0)
        else $error("payload without event");
endmodule

bind per_body_event_queue_pool pbeq_checker #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .has_event(has_event), .event_out(event_out), .flag(flag)
);
`default_nettype wire

>>> dv/tb_per_body_event_queue_pool.sv
`timescale 1ns / 1ps
module tb_per_body_event_queue_pool;
    import pbeq_pkg::*;

    localparam int POOL_DEPTH = 64;
    localparam int BODY_SLOTS = 512;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic        flag;
        logic        has_event;
        logic [31:0] event_out;
        logic        last;
    } result_t;

    class event_pool_scoreboard;
        logic [31:0] payloads[POOL_DEPTH];
        int          links[POOL_DEPTH];
        int          used;
        int          head[BODY_SLOTS];
        int          tail[BODY_SLOTS];
        int          length[BODY_SLOTS];
        logic [7:0]  masks[BODY_SLOTS];
        int          dyn_count;
        int          stat_count;
        result_t     pending[$];
        int          mismatches;

        function void clear_state();
            used = 0;
            dyn_count = 256;
            stat_count = 256;
            mismatches = 0;
            foreach (length[i])
            begin
                length[i] = 0;
                masks[i] = '0;
                head[i] = 0;
                tail[i] = 0;
            end
        endfunction

        function void write_count(int idx, int value);
            if (idx == CFG_DYNAMIC)
                dyn_count = value;
            else
                stat_count = value;
        endfunction

        function void add_result(logic [1:0] st, logic fl, logic he, logic [31:0] data,
                                 logic lst);
            result_t r;
            r.status = st;
            r.flag = fl;
            r.has_event = he;
            r.event_out = data;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_word(action_t act, logic kind, logic [7:0] idx,
                                logic [7:0] emask, logic [31:0] data);
            int slot;
            int lim;
            int cur;
            lim = kind ? stat_count : dyn_count;
            if (act == ACT_RESET)
            begin
                used = 0;
                foreach (length[i])
                    length[i] = 0;
                add_result(ST_OK, 0, 0, '0, 1);
                return;
            end
            if (idx >= lim)
            begin
                add_result(ST_INVALID, 0, 0, '0, 1);
                return;
            end
            slot = kind * 256 + idx;
            case (act)
                ACT_SUB:   masks[slot] |= emask;
                ACT_UNSUB: masks[slot] &= ~emask;
                ACT_UNALL: masks[slot] = '0;
                ACT_QUERY:
                begin
                    add_result(ST_OK, (masks[slot] & emask) != 0, 0, '0, 1);
                    return;
                end
                ACT_PUSH:
                begin
                    if (used >= POOL_DEPTH)
                    begin
                        add_result(ST_FULL, 0, 0, '0, 1);
                        return;
                    end
                    payloads[used] = data;
                    if (length[slot] > 0)
                        links[tail[slot]] = used;
                    else
                        head[slot] = used;
                    tail[slot] = used;
                    length[slot]++;
                    used++;
                end
                ACT_ANY:
                begin
                    add_result(ST_OK, length[slot] != 0, 0, '0, 1);
                    return;
                end
                ACT_ENUM:
                begin
                    if (length[slot] == 0)
                        add_result(ST_OK, 0, 0, '0, 1);
                    cur = head[slot];
                    for (int i = 0; i < length[slot]; i++)
                    begin
                        add_result(ST_OK, 0, 1, payloads[cur], i + 1 == length[slot]);
                        cur = links[cur];
                    end
                    return;
                end
                default: ;
            endcase
            add_result(ST_OK, 0, 0, '0, 1);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] action;
    logic body_kind;
    logic [7:0] body_index;
    logic [7:0] event_mask;
    logic [31:0] event_data;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic flag;
    logic has_event;
    logic [31:0] event_out;
    logic last;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    event_pool_scoreboard sb;
    int cycles;

    per_body_event_queue_pool dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall per word
    initial
    begin
        int gap;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0)
            begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_word({status, flag, has_event, event_out, last});
        end
    end

    // in_valid stays high after an accept until the next word or an idle gap
    task automatic send_word(action_t act, logic kind, logic [7:0] idx, logic [7:0] emask,
                             logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        body_kind <= kind;
        body_index <= idx;
        event_mask <= emask;
        event_data <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(act, kind, idx, emask, data);
    endtask

    task automatic set_count(int idx, int value);
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= CFG_INDEX_WIDTH'(idx);
        cfg_data <= CFG_WIDTH'(value);
        @(posedge clk);
        sb.write_count(idx, value);
        cfg_we <= 0;
    endtask

    task automatic random_word(int body_span);
        int r;
        action_t act;
        r = $urandom_range(0, 99);
        if (r < 35)
            act = ACT_PUSH;
        else if (r < 50)
            act = ACT_ENUM;
        else if (r < 52)
            act = ACT_RESET;
        else
            act = action_t'($urandom_range(0, 5));
        send_word(act, 1'($urandom_range(0, 1)), 8'($urandom_range(0, body_span)),
                  8'($urandom_range(0, 255)), $urandom());
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        cycles = 0;
        rst_n = 0;
        in_valid = 0;
        action = '0;
        body_kind = 0;
        body_index = '0;
        event_mask = '0;
        event_data = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: each action, table edges, full pool, empty walk
        send_word(ACT_ENUM, 0, 8'd0, 8'h00, '0);
        send_word(ACT_SUB, 0, 8'd255, 8'hFF, '0);
        send_word(ACT_QUERY, 0, 8'd255, 8'h80, '0);
        send_word(ACT_UNSUB, 0, 8'd255, 8'h80, '0);
        send_word(ACT_QUERY, 0, 8'd255, 8'h80, '0);
        send_word(ACT_UNALL, 0, 8'd255, 8'h00, '0);
        send_word(ACT_QUERY, 0, 8'd255, 8'hFF, '0);
        send_word(ACT_ANY, 1, 8'd0, 8'h00, '0);
        send_word(ACT_PUSH, 1, 8'd0, 8'h00, 32'hFFFFFFFF);
        send_word(ACT_PUSH, 1, 8'd0, 8'h00, 32'h00000000);
        send_word(ACT_ANY, 1, 8'd0, 8'h00, '0);
        for (int i = 0; i < 64; i++)
            send_word(ACT_PUSH, i[0], 8'd7, 8'h00, $urandom());
        send_word(ACT_ENUM, 1, 8'd7, 8'h00, '0);
        send_word(ACT_ENUM, 1, 8'd0, 8'h00, '0);
        send_word(ACT_RESET, 0, 8'd0, 8'h00, '0);
        send_word(ACT_ANY, 1, 8'd0, 8'h00, '0);

        set_count(CFG_DYNAMIC, 0);
        set_count(CFG_STATIC, 1);
        send_word(ACT_PUSH, 0, 8'd0, 8'h00, 32'h1);
        send_word(ACT_PUSH, 1, 8'd1, 8'h00, 32'h2);
        send_word(ACT_PUSH, 1, 8'd0, 8'h00, 32'h3);
        for (int i = 0; i < 40; i++)
            random_word(2);

        set_count(CFG_DYNAMIC, 5);
        set_count(CFG_STATIC, 256);
        for (int i = 0; i < 50; i++)
            random_word(7);

        set_count(CFG_DYNAMIC, 256);
        set_count(CFG_STATIC, 3);
        for (int i = 0; i < 40; i++)
            random_word($urandom_range(0, 1) ? 255 : 5);

        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> per_body_event_queue_pool.f
src/pbeq_pkg.sv
src/pbeq_body_mem.sv
src/per_body_event_queue_pool.sv
src/pbeq_checker.sv
dv/tb_per_body_event_queue_pool.sv
